@@ src/ctr_pkg.sv @@
// shared types and constants for the control trigger repeat block
// no dependencies; imported by every other file of the block except ctr_out_if
package ctr_pkg;

  localparam int DELAY_SLOTS_DEF = 4;
  localparam int TABLE_MAX       = 4;
  localparam int MS_W            = 16;
  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_DATA_W      = 16;

  localparam logic [MS_W-1:0] TIMER_MAX       = 16'hFFFF;
  localparam logic [MS_W-1:0] DEFAULT_LONG_MS  = 16'd1000;
  localparam logic [MS_W-1:0] DEFAULT_SHORT_MS = 16'd100;

  // operating modes
  localparam logic [1:0] MODE_LEVEL   = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_REPEAT  = 2'd2;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_MODE         = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DELAY_COUNT  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DELAY_FIRST  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_DELAY_SECOND = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_DELAY_THIRD  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_DELAY_FOURTH = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_ALLOW_WIDGET = 3'd6;

  typedef struct packed {
    logic [1:0]                      mode;
    logic [2:0]                      delay_count;
    logic [TABLE_MAX-1:0][MS_W-1:0]  delay_ms;
    logic                            allow_over_widget;
  } cfg_t;

endpackage

@@ src/ctr_in_if.sv @@
// input channel carrying one update sample per item
// depends on ctr_pkg for field widths
interface ctr_in_if;
  logic                        valid;
  logic                        ready;
  logic                        other_active;
  logic                        mouse_active;
  logic                        widget_under_mouse;
  logic [ctr_pkg::MS_W-1:0]    elapsed_ms;

  modport source (output valid, other_active, mouse_active, widget_under_mouse, elapsed_ms,
                  input ready);
  modport sink   (input valid, other_active, mouse_active, widget_under_mouse, elapsed_ms,
                  output ready);
endinterface

@@ src/ctr_out_if.sv @@
// result channel carrying the fire decision per item
// no dependencies
interface ctr_out_if;
  logic valid;
  logic ready;
  logic fire;
  logic fired_by_mouse;

  modport source (output valid, fire, fired_by_mouse, input ready);
  modport sink   (input valid, fire, fired_by_mouse, output ready);
endinterface

@@ src/ctr_cfg_regs.sv @@
// configuration register bank with write-only port
// depends on ctr_pkg
module ctr_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ctr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [ctr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output ctr_pkg::cfg_t                   cfg
);
  import ctr_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode              <= MODE_RELEASE;
      cfg_r.delay_count       <= 3'd0;
      cfg_r.delay_ms[0]       <= DEFAULT_LONG_MS;
      cfg_r.delay_ms[1]       <= DEFAULT_SHORT_MS;
      cfg_r.delay_ms[2]       <= DEFAULT_SHORT_MS;
      cfg_r.delay_ms[3]       <= DEFAULT_SHORT_MS;
      cfg_r.allow_over_widget <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MODE:         cfg_r.mode              <= cfg_wdata[1:0];
        REG_DELAY_COUNT:  cfg_r.delay_count       <= cfg_wdata[2:0];
        REG_DELAY_FIRST:  cfg_r.delay_ms[0]       <= cfg_wdata[MS_W-1:0];
        REG_DELAY_SECOND: cfg_r.delay_ms[1]       <= cfg_wdata[MS_W-1:0];
        REG_DELAY_THIRD:  cfg_r.delay_ms[2]       <= cfg_wdata[MS_W-1:0];
        REG_DELAY_FOURTH: cfg_r.delay_ms[3]       <= cfg_wdata[MS_W-1:0];
        REG_ALLOW_WIDGET: cfg_r.allow_over_widget <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ src/ctr_core.sv @@
// input register, trigger state and decision logic, result register
// depends on ctr_pkg, ctr_in_if and ctr_out_if
module ctr_core #(
  parameter int DELAY_SLOTS = ctr_pkg::DELAY_SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ctr_pkg::cfg_t cfg,
  ctr_in_if.sink        in_ch,
  ctr_out_if.source     out_ch
);
  import ctr_pkg::*;

  localparam logic [2:0] LIM = 3'((DELAY_SLOTS < TABLE_MAX) ? DELAY_SLOTS : TABLE_MAX);

  // input stage
  logic            s1_valid_r;
  logic            s1_other_r, s1_mouse_r, s1_widget_r;
  logic [MS_W-1:0] s1_elapsed_r;

  // trigger state
  logic            was_active_r, was_mouse_r, began_over_r;
  logic [1:0]      slot_r;
  logic [MS_W-1:0] since_r;

  // result stage
  logic            out_valid_r, fire_r, by_mouse_r;

  logic            s2_ready, in_ready;
  logic            cur, press, repeat_hit, fire_nxt, by_mouse_nxt;
  logic            began_mid, began_nxt;
  logic [MS_W:0]   t_sum;
  logic [MS_W-1:0] t_sat, entry, since_nxt;
  logic [2:0]      n, n_last, idx_inc;
  logic [1:0]      idx, slot_nxt;

  assign s2_ready = !out_valid_r || out_ch.ready;
  assign in_ready = !s1_valid_r || s2_ready;

  always_comb begin
    cur       = s1_other_r || s1_mouse_r;
    t_sum     = {1'b0, since_r} + {1'b0, s1_elapsed_r};
    t_sat     = t_sum[MS_W] ? TIMER_MAX : t_sum[MS_W-1:0];
    began_mid = began_over_r || (s1_widget_r && s1_mouse_r && !was_mouse_r);

    // table length in use, and the current index clamped into it
    if (cfg.delay_count == 3'd0) n = 3'd2;
    else if (cfg.delay_count > LIM) n = LIM;
    else n = cfg.delay_count;
    n_last  = n - 3'd1;
    idx     = ({1'b0, slot_r} >= n) ? n_last[1:0] : slot_r;
    idx_inc = {1'b0, idx} + 3'd1;

    if (cfg.delay_count == 3'd0) entry = (idx == 2'd0) ? DEFAULT_LONG_MS : DEFAULT_SHORT_MS;
    else entry = cfg.delay_ms[idx];

    press      = !was_active_r && cur;
    repeat_hit = cur && (t_sat >= entry);

    since_nxt    = t_sat;
    slot_nxt     = slot_r;
    fire_nxt     = 1'b0;
    by_mouse_nxt = 1'b0;
    case (cfg.mode)
      MODE_RELEASE: begin
        fire_nxt     = was_active_r && !cur;
        by_mouse_nxt = fire_nxt && was_mouse_r;
      end
      MODE_REPEAT: begin
        slot_nxt = idx;
        if (press) begin
          since_nxt = '0;
          slot_nxt  = 2'd0;
          fire_nxt  = 1'b1;
        end else if (repeat_hit) begin
          since_nxt = '0;
          slot_nxt  = (idx_inc >= n) ? n_last[1:0] : idx_inc[1:0];
          fire_nxt  = 1'b1;
        end
        by_mouse_nxt = fire_nxt && s1_mouse_r;
      end
      default: begin
        fire_nxt     = cur;
        by_mouse_nxt = cur && s1_mouse_r;
      end
    endcase

    // mouse press begun over a widget is suppressed unless allow_over_widget is set
    if (began_mid && !cfg.allow_over_widget) begin
      fire_nxt     = 1'b0;
      by_mouse_nxt = 1'b0;
    end
    began_nxt = (was_mouse_r && !s1_mouse_r) ? 1'b0 : began_mid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      was_active_r <= 1'b0;
      was_mouse_r  <= 1'b0;
      began_over_r <= 1'b0;
      slot_r       <= 2'd0;
      since_r      <= '0;
    end else begin
      if (in_ready) s1_valid_r <= in_ch.valid;
      if (s2_ready) out_valid_r <= s1_valid_r;
      if (s1_valid_r && s2_ready) begin
        was_active_r <= cur;
        was_mouse_r  <= s1_mouse_r;
        began_over_r <= began_nxt;
        slot_r       <= slot_nxt;
        since_r      <= since_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ready) begin
      s1_other_r   <= in_ch.other_active;
      s1_mouse_r   <= in_ch.mouse_active;
      s1_widget_r  <= in_ch.widget_under_mouse;
      s1_elapsed_r <= in_ch.elapsed_ms;
    end
    if (s1_valid_r && s2_ready) begin
      fire_r     <= fire_nxt;
      by_mouse_r <= by_mouse_nxt;
    end
  end

  assign in_ch.ready           = in_ready;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.fire           = fire_r;
  assign out_ch.fired_by_mouse = by_mouse_r;

endmodule

@@ src/control_trigger_repeat_core.sv @@
// an accepted item is held in the input register, then in the result register,
// from which its result is taken
// throughput: one item per cycle; the single state update per item sits
// between the input register and the result register; a held result stalls
// the input once both registers are full
// reset (synchronous, rst_n low): trigger state and timer cleared, mode is
// fire on release, default delay table of 1000 then 100 ms, widget cancel on
module control_trigger_repeat_core #(
  parameter int DELAY_SLOTS = ctr_pkg::DELAY_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ctr_in_if.sink                          in_ch,
  ctr_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [ctr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [ctr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import ctr_pkg::*;

  cfg_t cfg;

  ctr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ctr_core #(
    .DELAY_SLOTS (DELAY_SLOTS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

@@ verif/ctr_trigger_checker.sv @@
// checker for the control trigger repeat block: predicts the fire decision per item
// depends on ctr_pkg and the ctr_in_if / ctr_out_if channel interfaces
`timescale 1ns / 1ps

module ctr_trigger_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  ctr_in_if                               in_mon,
  ctr_out_if                              out_mon,
  input  logic                            cfg_we,
  input  logic [ctr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [ctr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                              mismatches,
  output int                              pending
);
  import ctr_pkg::*;

  typedef struct packed {
    logic fire;
    logic by_mouse;
  } fire_decision_t;

  // register copy
  logic [1:0]      mode_r;
  logic [2:0]      table_count;
  logic [MS_W-1:0] delay_tab [TABLE_MAX];
  logic            allow_widget;

  // trigger state
  logic            held_active;
  logic            held_mouse;
  logic            widget_latched;
  logic [1:0]      repeat_slot;
  logic [MS_W-1:0] ms_since_fire;

  fire_decision_t  expected_fires [$];
  int              results_seen;

  initial mismatches = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
    mismatches++;
  endtask

  function automatic fire_decision_t predict_trigger(input logic other, input logic mouse,
                                                     input logic widget,
                                                     input logic [MS_W-1:0] elapsed);
    fire_decision_t  res;
    logic            cur;
    logic            prev;
    logic            prev_mouse;
    logic [MS_W:0]   sum;
    int unsigned     n_slots;
    int unsigned     cap;
    int unsigned     slot;
    logic [MS_W-1:0] due_ms;
    cur        = other | mouse;
    prev       = held_active;
    prev_mouse = held_mouse;
    res        = '0;

    // timer saturates rather than wrapping
    sum           = {1'b0, ms_since_fire} + {1'b0, elapsed};
    ms_since_fire = sum[MS_W] ? TIMER_MAX : sum[MS_W-1:0];

    if (widget && mouse && !prev_mouse) widget_latched = 1'b1;

    case (mode_r)
      MODE_RELEASE: begin
        res.fire     = prev && !cur;
        res.by_mouse = res.fire && prev_mouse;
      end
      MODE_REPEAT: begin
        cap     = (DELAY_SLOTS_DEF < TABLE_MAX) ? DELAY_SLOTS_DEF : TABLE_MAX;
        n_slots = (table_count == 3'd0) ? 32'd2 : 32'(table_count);
        if (n_slots > cap) n_slots = cap;
        // a slot left over from a larger table falls back to the last entry
        slot = 32'(repeat_slot);
        if (slot >= n_slots) slot = n_slots - 1;
        if (table_count == 3'd0) begin
          due_ms = (slot == 0) ? DEFAULT_LONG_MS : DEFAULT_SHORT_MS;
        end else begin
          due_ms = delay_tab[slot[1:0]];
        end
        if (!prev && cur) begin
          ms_since_fire = '0;
          slot          = 0;
          res.fire      = 1'b1;
        end else if (cur && ms_since_fire >= due_ms) begin
          ms_since_fire = '0;
          slot          = slot + 1;
          if (slot >= n_slots) slot = n_slots - 1;
          res.fire      = 1'b1;
        end
        repeat_slot  = slot[1:0];
        res.by_mouse = res.fire && mouse;
      end
      default: begin
        res.fire     = cur;
        res.by_mouse = res.fire && mouse;
      end
    endcase

    if (widget_latched && !allow_widget) res = '0;
    if (prev_mouse && !mouse) widget_latched = 1'b0;

    held_active = cur;
    held_mouse  = mouse;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    fire_decision_t want;
    if (!rst_n) begin
      mode_r         = MODE_RELEASE;
      table_count    = '0;
      delay_tab      = '{DEFAULT_LONG_MS, DEFAULT_SHORT_MS, DEFAULT_SHORT_MS, DEFAULT_SHORT_MS};
      allow_widget   = 1'b0;
      held_active    = 1'b0;
      held_mouse     = 1'b0;
      widget_latched = 1'b0;
      repeat_slot    = '0;
      ms_since_fire  = '0;
      results_seen   = 0;
      expected_fires.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_MODE:         mode_r       = cfg_wdata[1:0];
          REG_DELAY_COUNT:  table_count  = cfg_wdata[2:0];
          REG_DELAY_FIRST:  delay_tab[0] = cfg_wdata[MS_W-1:0];
          REG_DELAY_SECOND: delay_tab[1] = cfg_wdata[MS_W-1:0];
          REG_DELAY_THIRD:  delay_tab[2] = cfg_wdata[MS_W-1:0];
          REG_DELAY_FOURTH: delay_tab[3] = cfg_wdata[MS_W-1:0];
          REG_ALLOW_WIDGET: allow_widget = cfg_wdata[0];
          default: ;
        endcase
      end

      if (out_mon.valid && out_mon.ready) begin
        if (expected_fires.size() == 0) begin
          report_mismatch("result with no item outstanding");
        end else begin
          want = expected_fires.pop_front();
          if (out_mon.fire !== want.fire)
            report_mismatch($sformatf("fire %b, expected %b", out_mon.fire, want.fire));
          if (out_mon.fired_by_mouse !== want.by_mouse)
            report_mismatch($sformatf("fired_by_mouse %b, expected %b",
                                      out_mon.fired_by_mouse, want.by_mouse));
        end
        results_seen++;
      end

      if (in_mon.valid && in_mon.ready) begin
        expected_fires = {expected_fires,
                          predict_trigger(in_mon.other_active, in_mon.mouse_active,
                                          in_mon.widget_under_mouse,
                                          in_mon.elapsed_ms)};
      end
    end
    pending <= expected_fires.size();
  end

endmodule

@@ verif/tb_control_trigger_repeat_core.sv @@
// top of the control trigger repeat testbench: clock, reset, item stimulus and verdict
// depends on ctr_pkg, the channel interfaces, the block and ctr_trigger_checker
`timescale 1ns / 1ps

module tb_control_trigger_repeat_core;
  import ctr_pkg::*;

  // fourth mode encoding, handled as level follow
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 72;
  localparam int PRESSURE_PHASE  = 8;
  localparam int PRESSURE_CYCLES = 300;
  localparam int STALL_LIMIT     = 4000;

  localparam logic [5:0][1:0] PHASE_MODES =
    {MODE_UNUSED, MODE_REPEAT, MODE_RELEASE, MODE_REPEAT, MODE_LEVEL, MODE_REPEAT};
  // idling profiles: none, sender, receiver, both
  localparam logic [3:0][6:0] SEND_IDLE  = {7'd35, 7'd0, 7'd56, 7'd0};
  localparam logic [3:0][6:0] RECV_STALL = {7'd35, 7'd56, 7'd0, 7'd0};

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;
  int pending_results;
  int mismatch_count;

  ctr_in_if  in_ch ();
  ctr_out_if out_ch ();

  control_trigger_repeat_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  ctr_trigger_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatch_count),
    .pending    (pending_results)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver: random stalls, or a long hold-off when asked
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("no handshake for %0d cycles", STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // narrow registers get random upper bits, which the block must ignore
  task automatic load_settings(input logic [1:0] md, input logic [2:0] cnt,
                               input logic [MS_W-1:0] d0, input logic [MS_W-1:0] d1,
                               input logic [MS_W-1:0] d2, input logic [MS_W-1:0] d3,
                               input logic allow);
    logic [CFG_DATA_W-1:0] junk;
    junk = 16'($urandom);
    write_reg(REG_MODE, {junk[CFG_DATA_W-1:2], md});
    write_reg(REG_DELAY_COUNT, {junk[CFG_DATA_W-1:3], cnt});
    write_reg(REG_DELAY_FIRST, d0);
    write_reg(REG_DELAY_SECOND, d1);
    write_reg(REG_DELAY_THIRD, d2);
    write_reg(REG_DELAY_FOURTH, d3);
    write_reg(REG_ALLOW_WIDGET, {junk[CFG_DATA_W-1:1], allow});
    cfg_we <= 1'b0;
  endtask

  task automatic send_sample(input logic other, input logic mouse, input logic widget,
                             input logic [MS_W-1:0] elapsed);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid              <= 1'b1;
    in_ch.other_active       <= other;
    in_ch.mouse_active       <= mouse;
    in_ch.widget_under_mouse <= widget;
    in_ch.elapsed_ms         <= elapsed;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // drop valid and wait for every outstanding result
  task automatic settle_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (3) @(posedge clk);
  endtask

  function automatic logic [MS_W-1:0] pick_elapsed();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 16'($urandom_range(0, 25));
    if (r < 85) return 16'($urandom_range(0, 300));
    if (r < 93) return 16'($urandom_range(0, 65535));
    if (r < 97) return '1;
    return '0;
  endfunction

  function automatic logic [MS_W-1:0] pick_delay();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return 16'($urandom_range(1, 60));
  endfunction

  initial begin
    int sent;
    int src;
    int hold_len;
    rst_n                    <= 1'b0;
    cfg_we                   <= 1'b0;
    cfg_addr                 <= REG_MODE;
    cfg_wdata                <= '0;
    in_ch.valid              <= 1'b0;
    in_ch.other_active       <= 1'b0;
    in_ch.mouse_active       <= 1'b0;
    in_ch.widget_under_mouse <= 1'b0;
    in_ch.elapsed_ms         <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: fire on release, widget cancel active, timer saturation
    send_sample(1'b1, 1'b0, 1'b0, 16'd65535);
    send_sample(1'b1, 1'b0, 1'b0, 16'd65535);
    send_sample(1'b0, 1'b0, 1'b0, 16'd0);
    send_sample(1'b0, 1'b1, 1'b0, 16'd0);
    send_sample(1'b0, 1'b0, 1'b0, 16'd0);
    send_sample(1'b0, 1'b1, 1'b1, 16'd1);
    send_sample(1'b0, 1'b0, 1'b0, 16'd0);
    send_sample(1'b1, 1'b1, 1'b1, 16'd0);
    send_sample(1'b0, 1'b0, 1'b0, 16'd0);
    settle_idle();

    // repeat with the default table, widget presses allowed
    load_settings(MODE_REPEAT, 3'd0, 16'd1000, 16'd100, 16'd100, 16'd100, 1'b1);
    send_sample(1'b0, 1'b1, 1'b1, 16'd0);
    send_sample(1'b0, 1'b1, 1'b0, 16'd999);
    send_sample(1'b0, 1'b1, 1'b0, 16'd1);
    send_sample(1'b0, 1'b1, 1'b0, 16'd100);
    send_sample(1'b1, 1'b0, 1'b0, 16'd65535);
    send_sample(1'b0, 1'b0, 1'b0, 16'd0);
    settle_idle();

    // full table walked to its last slot
    load_settings(MODE_REPEAT, 3'd4, 16'd0, 16'd65535, 16'd3, 16'd2, 1'b0);
    send_sample(1'b1, 1'b0, 1'b0, 16'd0);
    send_sample(1'b1, 1'b0, 1'b0, 16'd0);
    send_sample(1'b1, 1'b0, 1'b0, 16'd65535);
    send_sample(1'b1, 1'b0, 1'b0, 16'd3);
    send_sample(1'b1, 1'b0, 1'b0, 16'd2);
    settle_idle();

    // table shrunk under a held press: stale slot
    load_settings(MODE_REPEAT, 3'd2, 16'd50, 16'd60, 16'd1, 16'd1, 1'b0);
    send_sample(1'b1, 1'b0, 1'b0, 16'd60);
    settle_idle();

    load_settings(MODE_UNUSED, 3'd7, 16'd5, 16'd5, 16'd5, 16'd5, 1'b0);
    send_sample(1'b0, 1'b1, 1'b0, 16'd5);
    send_sample(1'b1, 1'b1, 1'b1, 16'd9);
    send_sample(1'b0, 1'b0, 1'b0, 16'd0);
    settle_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      send_idle_pct  = int'(SEND_IDLE[2'(ph % 4)]);
      recv_stall_pct = int'(RECV_STALL[2'(ph % 4)]);
      if (ph == 0) begin
        load_settings(PHASE_MODES[3'(ph % 6)], 3'd4, '0, '0, '0, '0, 1'b0);
      end else if (ph == 2) begin
        load_settings(PHASE_MODES[3'(ph % 6)], 3'd4, '1, '1, '1, '1, 1'b1);
      end else begin
        load_settings(PHASE_MODES[3'(ph % 6)], 3'($urandom_range(0, 7)), pick_delay(),
                      pick_delay(), pick_delay(), pick_delay(), 1'($urandom_range(0, 1)));
      end
      if (ph == PRESSURE_PHASE) hold_left = PRESSURE_CYCLES;

      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 99) < 15) begin
          send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), pick_elapsed());
          sent++;
        end else begin
          // press, hold, release; src 0 other, 1 mouse, 2 both
          src      = $urandom_range(0, 2);
          hold_len = $urandom_range(0, 14);
          send_sample(src != 1, src != 0, 1'($urandom_range(0, 1)), pick_elapsed());
          for (int h = 0; h < hold_len; h++)
            send_sample(src != 1, src != 0, 1'($urandom_range(0, 1)), pick_elapsed());
          send_sample(1'b0, 1'b0, 1'($urandom_range(0, 1)), pick_elapsed());
          sent += hold_len + 2;
        end
      end
      settle_idle();
    end

    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ control_trigger_repeat_core.f @@
src/ctr_pkg.sv
src/ctr_in_if.sv
src/ctr_out_if.sv
src/ctr_cfg_regs.sv
src/ctr_core.sv
src/control_trigger_repeat_core.sv
verif/ctr_trigger_checker.sv
verif/tb_control_trigger_repeat_core.sv
